@@ rtl/core/fmdv_pkg.sv @@
// ----------------------------------------------------------------------------
// fmdv_pkg: shared types and constants for the FM drum voice
// Register indexes, algorithm codes, sequencer states, unit interfaces and
// the sine table generator used at elaboration.
// ----------------------------------------------------------------------------
package fmdv_pkg;

  // Sine table address width default
  localparam int unsigned SINE_ADDR_BITS_DEF = 8;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_CARRIER_STEP   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MODULATOR_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MOD_DEPTH      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_LENGTH   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_OUT_LEVEL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALGORITHM      = 3'd5;

  // Register reset values
  localparam logic [31:0] CARRIER_STEP_RST   = 32'd26843500;
  localparam logic [31:0] MODULATOR_STEP_RST = 32'd40265250;
  localparam logic [15:0] MOD_DEPTH_RST      = 16'd4096;
  localparam logic [15:0] DECAY_LENGTH_RST   = 16'd2000;
  localparam logic [7:0]  OUT_LEVEL_RST      = 8'd200;

  // Algorithm codes
  localparam logic [1:0] ALG_PLAIN    = 2'd0;
  localparam logic [1:0] ALG_STRONG   = 2'd1;
  localparam logic [1:0] ALG_MOD_FB   = 2'd2;
  localparam logic [1:0] ALG_NOISE    = 2'd3;

  // Voice constants
  localparam logic [15:0] ENV_ACCENT = 16'd65535;
  localparam logic [15:0] ENV_NORMAL = 16'd52428;
  localparam logic [31:0] NOISE_SEED = 32'h12345678;
  localparam logic signed [16:0] MIX_FM    = 17'sd179;
  localparam logic signed [16:0] MIX_NOISE = 17'sd77;

  // Reciprocal divider: 65536 needs 17 quotient bits
  localparam int unsigned DIV_BITS = 17;
  localparam logic [DIV_BITS-1:0] DIV_DIVIDEND = 17'h10000;

  // Configuration register set
  typedef struct packed {
    logic [31:0] carrier_step;
    logic [31:0] modulator_step;
    logic [15:0] mod_depth;
    logic [15:0] decay_length;
    logic [7:0]  out_level;
    logic [1:0]  algorithm;
  } cfg_t;

  // Operands for the shared multiplier
  typedef struct packed {
    logic signed [16:0] a;
    logic signed [16:0] b;
  } mul_req_t;

  // Divider status
  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quot;
  } div_stat_t;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MADDR,
    ST_MSIN,
    ST_OFFS,
    ST_CSIN,
    ST_ENV,
    ST_MIX1,
    ST_MIX2,
    ST_LVL,
    ST_LVLW,
    ST_DEC,
    ST_OUT
  } state_t;

  // Sine table entry: round(32767*sin) over a quarter wave, Taylor series in Q31.
  // Evaluated only with constant arguments while the table is elaborated.
  function automatic logic signed [15:0] sine_entry(input int unsigned idx,
                                                    input int unsigned abits);
    logic [63:0] half;
    logic [63:0] q_shift;
    logic [63:0] j;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] v;
    half    = 64'd1 << (abits - 1);
    q_shift = 64'(abits - 2);
    j       = 64'(idx) & (half - 64'd1);
    if (j > (64'd1 << q_shift)) begin
      j = half - j;
    end
    x  = (64'd3373259426 * j) >> q_shift;
    x2 = (x * x) >> 31;
    t  = 64'd1 << 31;
    t  = (64'd1 << 31) - ((x2 * t) >> 31) / 64'd272;
    t  = (64'd1 << 31) - ((x2 * t) >> 31) / 64'd210;
    t  = (64'd1 << 31) - ((x2 * t) >> 31) / 64'd156;
    t  = (64'd1 << 31) - ((x2 * t) >> 31) / 64'd110;
    t  = (64'd1 << 31) - ((x2 * t) >> 31) / 64'd72;
    t  = (64'd1 << 31) - ((x2 * t) >> 31) / 64'd42;
    t  = (64'd1 << 31) - ((x2 * t) >> 31) / 64'd20;
    t  = (64'd1 << 31) - ((x2 * t) >> 31) / 64'd6;
    s  = (x * t) >> 31;
    v  = (s * 64'd32767 + (64'd1 << 30)) >> 31;
    if (64'(idx) >= half) begin
      return -$signed(v[15:0]);
    end
    return $signed(v[15:0]);
  endfunction

endpackage

@@ rtl/core/fmdv_sine_rom.sv @@
// ----------------------------------------------------------------------------
// fmdv_sine_rom: constant sine table with registered read
// One full wave of 2^ADDR_BITS signed 16-bit entries, filled at elaboration.
// ----------------------------------------------------------------------------
module fmdv_sine_rom import fmdv_pkg::*; #(
  parameter int unsigned ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic [ADDR_BITS-1:0] addr,
  output logic signed [15:0]   data_r
);

  localparam int unsigned DEPTH = 1 << ADDR_BITS;

  logic signed [15:0] tbl [DEPTH];

  // Fill the table with constants
  for (genvar i = 0; i < DEPTH; i++) begin : g_tbl
    localparam logic signed [15:0] ENTRY = sine_entry(32'(i), ADDR_BITS);
    assign tbl[i] = ENTRY;
  end

  // Register the read
  always_ff @(posedge clk) begin
    data_r <= tbl[addr];
  end

endmodule

@@ rtl/core/fmdv_mul.sv @@
// ----------------------------------------------------------------------------
// fmdv_mul: shared signed multiplier
// One 17x17 signed product per cycle, registered at the output.
// ----------------------------------------------------------------------------
module fmdv_mul import fmdv_pkg::*; (
  input  logic               clk,
  input  mul_req_t           req,
  output logic signed [33:0] prod_r
);

  // Multiply and hold the product for the next sequencer step
  always_ff @(posedge clk) begin
    prod_r <= req.a * req.b;
  end

endmodule

@@ rtl/core/fmdv_div.sv @@
// ----------------------------------------------------------------------------
// fmdv_div: iterative envelope step divider
// Restoring division of 65536 by the decay length, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module fmdv_div import fmdv_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [15:0] divisor,
  output div_stat_t   stat
);

  localparam int unsigned CNT_W = $clog2(DIV_BITS + 1);

  logic [15:0]         rem_r,  rem_nxt;
  logic [DIV_BITS-1:0] quo_r,  quo_nxt;
  logic [CNT_W-1:0]    cnt_r,  cnt_nxt;
  logic                busy_r, busy_nxt;
  logic                done_r, done_nxt;
  logic [16:0]         trial;
  logic [16:0]         diff;

  // One restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial    = {rem_r, quo_r[DIV_BITS-1]};
    diff     = trial - {1'b0, divisor};
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = done_r;
    if (start) begin
      rem_nxt  = '0;
      quo_nxt  = DIV_DIVIDEND;
      cnt_nxt  = CNT_W'(DIV_BITS);
      busy_nxt = 1'b1;
      done_nxt = 1'b0;
    end else if (busy_r) begin
      if (trial >= {1'b0, divisor}) begin
        rem_nxt = diff[15:0];
        quo_nxt = {quo_r[DIV_BITS-2:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[DIV_BITS-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CNT_W'(1);
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.done = done_r;
  assign stat.quot = quo_r;

endmodule

@@ rtl/core/fmdv_core.sv @@
// ----------------------------------------------------------------------------
// fmdv_core: voice sequencer and state
// Steps one tick through the sine table, the shared multiplier and the
// divider, keeps phases, envelope, feedback and noise, and holds the result.
// ----------------------------------------------------------------------------
module fmdv_core import fmdv_pkg::*; #(
  parameter int unsigned ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  cfg_t                 cfg,
  // item input
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 in_mode,
  input  logic                 in_accent,
  // result output
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [15:0]   out_sample,
  output logic [9:0]           out_duty,
  // sine table
  output logic [ADDR_BITS-1:0] rom_addr,
  input  logic signed [15:0]   rom_data,
  // shared multiplier
  output mul_req_t             mul_req,
  input  logic signed [33:0]   prod,
  // divider
  output logic                 div_start,
  input  div_stat_t            div_stat
);

  state_t state_r, state_nxt;

  logic [31:0]        car_ph_r, car_ph_nxt;
  logic [31:0]        mod_ph_r, mod_ph_nxt;
  logic [15:0]        env_r,    env_nxt;
  logic signed [15:0] fb_r,     fb_nxt;
  logic [31:0]        noise_r,  noise_nxt;
  logic               on_r,     on_nxt;
  logic               oval_r,   oval_nxt;

  logic signed [15:0] m_r,    m_nxt;
  logic signed [15:0] fmv_r,  fmv_nxt;
  logic signed [15:0] nz_r,   nz_nxt;
  logic signed [24:0] acc_r,  acc_nxt;
  logic signed [15:0] smp_r,  smp_nxt;
  logic signed [15:0] osmp_r, osmp_nxt;
  logic [9:0]         oduty_r, oduty_nxt;

  logic               active;
  logic               accept;
  logic               out_free;
  logic               is_noise;
  logic               dec_ready;
  logic signed [15:0] fb_sh;
  logic [31:0]        mphase;
  logic signed [15:0] fm_off;
  logic [31:0]        cphase;
  logic [31:0]        nx;
  logic signed [24:0] mix_sum;

  assign active    = on_r && (env_r != 16'd0);
  assign accept    = in_valid && in_ready;
  assign out_free  = !oval_r || out_ready;
  assign is_noise  = (cfg.algorithm == ALG_NOISE);
  assign dec_ready = (cfg.decay_length == 16'd0) || div_stat.done;

  // Modulator phase with optional self feedback
  assign fb_sh  = fb_r >>> 3;
  assign mphase = mod_ph_r + ((cfg.algorithm == ALG_MOD_FB) ?
                  {{16{fb_sh[15]}}, fb_sh} : 32'd0);

  // FM offset: arithmetic shift of the modulator product, kept to 16 bits
  assign fm_off = (cfg.algorithm == ALG_STRONG) ? prod[27:12] : prod[29:14];
  assign cphase = car_ph_r + {{16{fm_off[15]}}, fm_off};

  // Xorshift advance
  always_comb begin
    nx = noise_r;
    nx = nx ^ (nx << 13);
    nx = nx ^ (nx >> 17);
    nx = nx ^ (nx << 5);
  end

  assign mix_sum = acc_r + prod[24:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && !in_mode) begin
          state_nxt = active ? ST_MADDR : ST_OUT;
        end
      end
      ST_MADDR: state_nxt = ST_MSIN;
      ST_MSIN:  state_nxt = ST_OFFS;
      ST_OFFS:  state_nxt = ST_CSIN;
      ST_CSIN:  state_nxt = ST_ENV;
      ST_ENV:   state_nxt = is_noise ? ST_MIX1 : ST_LVL;
      ST_MIX1:  state_nxt = ST_MIX2;
      ST_MIX2:  state_nxt = ST_LVL;
      ST_LVL:   state_nxt = ST_LVLW;
      ST_LVLW:  state_nxt = ST_DEC;
      ST_DEC: begin
        if (dec_ready) begin
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Unit controls: table address, multiplier operands, divider start
  always_comb begin
    in_ready  = 1'b0;
    rom_addr  = '0;
    mul_req   = '0;
    div_start = 1'b0;
    unique case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_MADDR: begin
        rom_addr  = mphase[31 -: ADDR_BITS];
        div_start = (cfg.decay_length != 16'd0);
      end
      ST_MSIN: begin
        mul_req.a = {rom_data[15], rom_data};
        mul_req.b = {1'b0, cfg.mod_depth};
      end
      ST_OFFS: rom_addr = cphase[31 -: ADDR_BITS];
      ST_CSIN: begin
        mul_req.a = is_noise ? {nx[31], nx[31:16]} : {rom_data[15], rom_data};
        mul_req.b = {1'b0, env_r};
      end
      ST_ENV: begin
        if (is_noise) begin
          mul_req.a = {fmv_r[15], fmv_r};
          mul_req.b = MIX_FM;
        end
      end
      ST_MIX1: begin
        mul_req.a = {nz_r[15], nz_r};
        mul_req.b = MIX_NOISE;
      end
      ST_LVL: begin
        mul_req.a = {smp_r[15], smp_r};
        mul_req.b = {9'd0, cfg.out_level};
      end
      ST_MIX2, ST_LVLW, ST_DEC, ST_OUT: begin
      end
      default: begin
      end
    endcase
  end

  // Datapath and voice state updates
  always_comb begin
    car_ph_nxt = car_ph_r;
    mod_ph_nxt = mod_ph_r;
    env_nxt    = env_r;
    fb_nxt     = fb_r;
    noise_nxt  = noise_r;
    on_nxt     = on_r;
    m_nxt      = m_r;
    fmv_nxt    = fmv_r;
    nz_nxt     = nz_r;
    acc_nxt    = acc_r;
    smp_nxt    = smp_r;
    osmp_nxt   = osmp_r;
    oduty_nxt  = oduty_r;
    oval_nxt   = oval_r && !out_ready;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && in_mode) begin
          // trigger: restart the voice
          car_ph_nxt = '0;
          mod_ph_nxt = '0;
          env_nxt    = in_accent ? ENV_ACCENT : ENV_NORMAL;
          fb_nxt     = '0;
          on_nxt     = 1'b1;
        end else if (accept && !active) begin
          smp_nxt = '0;
        end
      end
      ST_MSIN: m_nxt = rom_data;
      ST_CSIN: begin
        fmv_nxt = rom_data;
        if (is_noise) begin
          noise_nxt = nx;
        end
      end
      ST_ENV: begin
        if (is_noise) begin
          nz_nxt = prod[31:16];
        end else begin
          smp_nxt = prod[31:16];
        end
      end
      ST_MIX1: acc_nxt = prod[24:0];
      ST_MIX2: smp_nxt = mix_sum[23:8];
      ST_LVLW: begin
        smp_nxt    = prod[23:8];
        car_ph_nxt = car_ph_r + cfg.carrier_step;
        mod_ph_nxt = mod_ph_r + cfg.modulator_step;
        if (cfg.algorithm == ALG_MOD_FB) begin
          fb_nxt = m_r;
        end
      end
      ST_DEC: begin
        // lower the envelope, go idle when it reaches zero
        if (cfg.decay_length != 16'd0 && div_stat.done) begin
          if ({1'b0, env_r} > div_stat.quot) begin
            env_nxt = env_r - div_stat.quot[15:0];
          end else begin
            env_nxt = '0;
            on_nxt  = 1'b0;
          end
        end
      end
      ST_OUT: begin
        if (out_free) begin
          osmp_nxt  = smp_r;
          oduty_nxt = {~smp_r[15], smp_r[14:6]};
          oval_nxt  = 1'b1;
        end
      end
      ST_MADDR, ST_OFFS, ST_LVL: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      car_ph_r <= '0;
      mod_ph_r <= '0;
      env_r    <= '0;
      fb_r     <= '0;
      noise_r  <= NOISE_SEED;
      on_r     <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      car_ph_r <= car_ph_nxt;
      mod_ph_r <= mod_ph_nxt;
      env_r    <= env_nxt;
      fb_r     <= fb_nxt;
      noise_r  <= noise_nxt;
      on_r     <= on_nxt;
      oval_r   <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    m_r     <= m_nxt;
    fmv_r   <= fmv_nxt;
    nz_r    <= nz_nxt;
    acc_r   <= acc_nxt;
    smp_r   <= smp_nxt;
    osmp_r  <= osmp_nxt;
    oduty_r <= oduty_nxt;
  end

  assign out_valid  = oval_r;
  assign out_sample = osmp_r;
  assign out_duty   = oduty_r;

endmodule

@@ rtl/core/fm_drum_voice_top.sv @@
// ----------------------------------------------------------------------------
// fm_drum_voice_top: two-operator FM drum voice
// Configuration registers, stream ports and the voice units.
// ----------------------------------------------------------------------------
// A trigger transfer (in_tuser = 1) restarts the voice and gives
// no result. A tick transfer (in_tuser = 0) gives one sample and its PWM duty:
// an idle voice goes straight to the output step, an active voice waits for
// the 17-step divider that forms the envelope decrement, which runs while the
// sequencer walks the sine table and the shared multiplier through the
// modulator, carrier, envelope, mix and level products. With a decay length of
// zero the divider is skipped; the noise mix adds the MIX1 and MIX2 states.
// in_tready is low while a tick is in work; a finished result waits
// in the output register and the next item is taken meanwhile, and a stalled
// result adds its stall to the following tick. Configuration is taken in
// every cycle.
module fm_drum_voice_top import fmdv_pkg::*; #(
  parameter int unsigned SINE_ADDR_BITS = SINE_ADDR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input stream
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] accent, [7:1] zero
  input  logic [0:0]           in_tuser,   // [0] mode: 0 tick, 1 trigger
  // result stream
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [31:0]          out_tdata,  // [15:0] voice_sample, [25:16] pwm_duty
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data
);

  cfg_t                     cfg_r;
  logic [SINE_ADDR_BITS-1:0] rom_addr;
  logic signed [15:0]        rom_data;
  mul_req_t                  mul_req;
  logic signed [33:0]        prod;
  logic                      div_start;
  div_stat_t                 div_stat;
  logic signed [15:0]        out_sample;
  logic [9:0]                out_duty;

  assign cfg_ready = 1'b1;

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.carrier_step   <= CARRIER_STEP_RST;
      cfg_r.modulator_step <= MODULATOR_STEP_RST;
      cfg_r.mod_depth      <= MOD_DEPTH_RST;
      cfg_r.decay_length   <= DECAY_LENGTH_RST;
      cfg_r.out_level      <= OUT_LEVEL_RST;
      cfg_r.algorithm      <= ALG_PLAIN;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CARRIER_STEP:   cfg_r.carrier_step   <= cfg_data;
        REG_MODULATOR_STEP: cfg_r.modulator_step <= cfg_data;
        REG_MOD_DEPTH:      cfg_r.mod_depth      <= cfg_data[15:0];
        REG_DECAY_LENGTH:   cfg_r.decay_length   <= cfg_data[15:0];
        REG_OUT_LEVEL:      cfg_r.out_level      <= cfg_data[7:0];
        REG_ALGORITHM:      cfg_r.algorithm      <= cfg_data[1:0];
        default: begin
        end
      endcase
    end
  end

  fmdv_core #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_mode    (in_tuser[0]),
    .in_accent  (in_tdata[0]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_sample (out_sample),
    .out_duty   (out_duty),
    .rom_addr   (rom_addr),
    .rom_data   (rom_data),
    .mul_req    (mul_req),
    .prod       (prod),
    .div_start  (div_start),
    .div_stat   (div_stat)
  );

  fmdv_sine_rom #(
    .ADDR_BITS (SINE_ADDR_BITS)
  ) u_rom (
    .clk    (clk),
    .addr   (rom_addr),
    .data_r (rom_data)
  );

  fmdv_mul u_mul (
    .clk    (clk),
    .req    (mul_req),
    .prod_r (prod)
  );

  fmdv_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .divisor (cfg_r.decay_length),
    .stat    (div_stat)
  );

  // Pack the result
  assign out_tdata = {6'd0, out_duty, out_sample};

endmodule

@@ rtl/core/fmdv_checker.sv @@
// ----------------------------------------------------------------------------
// fmdv_checker: port-level checks for the FM drum voice
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module fmdv_checker import fmdv_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_tvalid,
  input logic                 in_tready,
  input logic [0:0]           in_tuser,
  input logic                 out_tvalid,
  input logic                 out_tready,
  input logic [31:0]          out_tdata
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // Duty follows the sample it travels with
  a_duty: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[25:16] == {~out_tdata[15], out_tdata[14:6]})
    else $error("pwm duty does not match sample");

  // A trigger transfer never produces a result
  a_trig_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser[0] |=> !$rose(out_tvalid))
    else $error("result after trigger");

  // A tick transfer occupies the voice
  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser[0] |=> !in_tready)
    else $error("input taken while a tick is in work");

endmodule

bind fm_drum_voice_top fmdv_checker u_fmdv_checker (.*);

@@ tb/sv/fm_drum_voice_checker.sv @@
// ----------------------------------------------------------------------------
// fm_drum_voice_checker: result predictor and scoreboard for the FM drum voice
// Watches the input, result and configuration channels. Keeps its own copy of
// the voice state and register set, predicts one sample and PWM duty per tick
// transfer, and compares every result transfer with the oldest prediction.
// ----------------------------------------------------------------------------
module fm_drum_voice_checker import fmdv_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  input  logic                 in_tready,
  input  logic [7:0]           in_tdata,   // [0] accent, [7:1] zero
  input  logic [0:0]           in_tuser,   // [0] mode: 0 tick, 1 trigger
  input  logic                 out_tvalid,
  input  logic                 out_tready,
  input  logic [31:0]          out_tdata,  // [15:0] voice_sample, [25:16] pwm_duty
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_data,
  output int                   errors,
  output int                   pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ABITS       = SINE_ADDR_BITS_DEF;
  localparam int unsigned TAB_SIZE    = 1 << ABITS;

  // One result item, laid out as in out_tdata
  typedef struct packed {
    logic [9:0]         duty;
    logic signed [15:0] sample;
  } voice_out_t;

  logic signed [15:0] sine_tab [TAB_SIZE];

  // Predicted register set and voice state
  cfg_t        regs;
  logic [31:0] car_ph;
  logic [31:0] mod_ph;
  logic [31:0] noise;
  logic [15:0] env;
  logic [15:0] fb_val;
  logic        active;

  voice_out_t  sample_q[$];

  // Quarter-wave sine in Q31, series evaluated from the highest term down
  function automatic logic [15:0] quarter_wave(input logic [63:0] j, input logic [63:0] q);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = 64'd3373259426 * j / q;
    x2 = (x * x) >> 31;
    t  = 64'd1 << 31;
    for (int k = 17; k >= 3; k -= 2) begin
      t = (64'd1 << 31) - ((x2 * t) >> 31) / (64'(k) * 64'(k - 1));
    end
    s = (x * t) >> 31;
    return 16'((s * 64'd32767 + (64'd1 << 30)) >> 31);
  endfunction

  // Fill the sine table by folding the quarter wave
  initial begin
    int unsigned j;
    logic [15:0] v;
    for (int i = 0; i < TAB_SIZE; i++) begin
      j = i % (TAB_SIZE / 2);
      if (j > TAB_SIZE / 4) begin
        j = TAB_SIZE / 2 - j;
      end
      v = quarter_wave(64'(j), 64'(TAB_SIZE / 4));
      sine_tab[i] = (i >= TAB_SIZE / 2) ? -$signed(v) : $signed(v);
    end
  end

  function automatic longint sine_lookup(input logic [31:0] ph);
    return sine_tab[ph[31 -: ABITS]];
  endfunction

  // Carrier sine with the modulator sine folded into its phase
  function automatic longint fm_tone(input logic [31:0] mph, input int shift,
                                     output longint m);
    longint      depth;
    longint      prod;
    logic [15:0] off;
    depth = regs.mod_depth;
    m     = sine_lookup(mph);
    prod  = (m * depth) >>> shift;
    off   = prod[15:0];
    return sine_lookup(car_ph + {{16{off[15]}}, off});
  endfunction

  // Work out the result of one tick and advance the voice
  task automatic predict_tick(output voice_out_t r);
    longint      s;
    longint      m;
    longint      fmv;
    longint      nz;
    longint      e;
    longint      lvl;
    longint      fb;
    longint      d;
    logic [31:0] x;
    logic [31:0] amt;
    s = 0;
    if (active && env != 16'd0) begin
      e   = env;
      lvl = regs.out_level;
      case (regs.algorithm)
        ALG_PLAIN: begin
          s = fm_tone(mod_ph, 14, m);
        end
        ALG_STRONG: begin
          s = fm_tone(mod_ph, 12, m);
        end
        ALG_MOD_FB: begin
          fb     = $signed(fb_val);
          fb     = fb >>> 3;
          s      = fm_tone(mod_ph + 32'(fb), 14, m);
          fb_val = m[15:0];
        end
        default: begin
          fmv   = fm_tone(mod_ph, 14, m);
          x     = noise;
          x     = x ^ (x << 13);
          x     = x ^ (x >> 17);
          x     = x ^ (x << 5);
          noise = x;
          nz    = $signed(x[31:16]);
          nz    = (nz * e) >>> 16;
          s     = (fmv * MIX_FM + nz * MIX_NOISE) >>> 8;
        end
      endcase
      // noise mix carries the envelope inside its noise term only
      if (regs.algorithm != ALG_NOISE) begin
        s = (s * e) >>> 16;
      end
      s      = (s * lvl) >>> 8;
      car_ph = car_ph + regs.carrier_step;
      mod_ph = mod_ph + regs.modulator_step;
      // linear decay, zero length holds the envelope
      if (regs.decay_length != 16'd0) begin
        amt = 32'h10000 / regs.decay_length;
        if (env > amt) begin
          env = env - amt[15:0];
        end else begin
          env    = 16'd0;
          active = 1'b0;
        end
      end
    end
    d = (s + 32768) >>> 6;
    if (d > 1023) begin
      d = 1023;
    end
    r.sample = s[15:0];
    r.duty   = d[9:0];
  endtask

  // Track transfers on all three channels
  always @(posedge clk) begin
    voice_out_t want;
    voice_out_t got;
    if (!rst_n) begin
      regs.carrier_step   = CARRIER_STEP_RST;
      regs.modulator_step = MODULATOR_STEP_RST;
      regs.mod_depth      = MOD_DEPTH_RST;
      regs.decay_length   = DECAY_LENGTH_RST;
      regs.out_level      = OUT_LEVEL_RST;
      regs.algorithm      = ALG_PLAIN;
      car_ph              = '0;
      mod_ph              = '0;
      noise               = NOISE_SEED;
      env                 = '0;
      fb_val              = '0;
      active              = 1'b0;
      errors              = 0;
      sample_q.delete();
    end else begin
      // compare a result transfer before queuing a new prediction
      if (out_tvalid && out_tready) begin
        got = out_tdata[25:0];
        if (sample_q.size() == 0) begin
          errors++;
          $display("%0t: result with none expected, actual sample %0d duty %0d",
                   $time, $signed(got.sample), got.duty);
        end else begin
          want = sample_q.pop_front();
          if (got.sample !== want.sample) begin
            errors++;
            $display("%0t: voice_sample expected %0d, actual %0d",
                     $time, $signed(want.sample), $signed(got.sample));
          end
          if (got.duty !== want.duty) begin
            errors++;
            $display("%0t: pwm_duty expected %0d, actual %0d",
                     $time, want.duty, got.duty);
          end
        end
      end

      // register write, unknown indexes are dropped
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_CARRIER_STEP:   regs.carrier_step   = cfg_data;
          REG_MODULATOR_STEP: regs.modulator_step = cfg_data;
          REG_MOD_DEPTH:      regs.mod_depth      = cfg_data[15:0];
          REG_DECAY_LENGTH:   regs.decay_length   = cfg_data[15:0];
          REG_OUT_LEVEL:      regs.out_level      = cfg_data[7:0];
          REG_ALGORITHM:      regs.algorithm      = cfg_data[1:0];
          default: ;
        endcase
      end

      // trigger restarts the voice, tick yields one result
      if (in_tvalid && in_tready) begin
        if (in_tuser[0]) begin
          car_ph = '0;
          mod_ph = '0;
          env    = in_tdata[0] ? ENV_ACCENT : ENV_NORMAL;
          fb_val = '0;
          active = 1'b1;
        end else begin
          predict_tick(want);
          sample_q.push_back(want);
        end
      end
    end
    pending = sample_q.size();
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the FM drum voice
// Drives a directed opening over register extremes and every algorithm, then
// random phases of trigger and tick transfers under random register settings,
// with random idling on both streams. The checker predicts and compares.
// ----------------------------------------------------------------------------
module testbench import fmdv_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE       = 30;
  localparam int RANDOM_ITEMS = 560;
  localparam int PHASE_ITEMS  = 72;

  logic                 clk;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;   // [0] accent, [7:1] zero
  logic [0:0]           in_tuser;   // [0] mode: 0 tick, 1 trigger
  logic                 out_tvalid;
  logic                 out_tready;
  logic [31:0]          out_tdata;  // [15:0] voice_sample, [25:16] pwm_duty
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_data;

  int errors;
  int pending;
  int quiet;
  bit steady;

  fm_drum_voice_top uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  fm_drum_voice_checker scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Result side stalls at random outside the steady stretch
  always @(posedge clk) begin
    out_tready <= steady || ($urandom_range(99) >= 7);
  end

  // Watchdog on cycles without any transfer
  always @(posedge clk) begin
    if (!rst_n) begin
      quiet <= 0;
    end else if ((in_tvalid && in_tready) || (out_tvalid && out_tready) ||
                 (cfg_valid && cfg_ready)) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("fm_drum_voice_top: mismatch");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // Present one item, with a random gap ahead of it
  task automatic send_item(input bit mode, input bit accent);
    while (!steady && $urandom_range(99) < 7) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {7'd0, accent};
    do @(posedge clk); while (!in_tready);
  endtask

  // Hold the input until every predicted result has been transferred
  task automatic wait_results();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // Let a trailing trigger settle as well before touching registers
  task automatic drain();
    wait_results();
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Write the whole register set, optionally with a stray index first
  task automatic write_settings(input logic [31:0] car_step, input logic [31:0] mod_step,
                                input logic [15:0] depth, input logic [15:0] decay,
                                input logic [7:0] level, input logic [1:0] alg,
                                input bit stray);
    if (stray) begin
      write_reg(CFG_IDX_W'(REG_ALGORITHM + 1 + $urandom_range(1)), $urandom);
    end
    write_reg(REG_CARRIER_STEP, car_step);
    write_reg(REG_MODULATOR_STEP, mod_step);
    write_reg(REG_MOD_DEPTH, {16'($urandom_range(65535)), depth});
    write_reg(REG_DECAY_LENGTH, {16'($urandom_range(65535)), decay});
    write_reg(REG_OUT_LEVEL, {24'($urandom), level});
    write_reg(REG_ALGORITHM, {30'($urandom), alg});
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] pick_step();
    case ($urandom_range(5))
      0:       return '0;
      1:       return '1;
      2:       return $urandom_range(32'h0400_0000, 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_decay();
    case ($urandom_range(7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3, 4:    return 16'($urandom_range(64, 2));
      5:       return 16'($urandom_range(3000, 65));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_depth();
    case ($urandom_range(3))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_level();
    case ($urandom_range(4))
      0:       return 8'd0;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin
    int sent;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    steady     = 1'b0;
    sent       = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: idle ticks, then accented and plain triggers
    send_item(1'b0, 1'b0);
    send_item(1'b0, 1'b1);
    send_item(1'b1, 1'b1);
    repeat (4) send_item(1'b0, 1'($urandom_range(1)));
    send_item(1'b1, 1'b0);
    repeat (2) send_item(1'b0, 1'($urandom_range(1)));
    drain();

    // Strong FM, full depth, shortest decay: one active tick, then idle
    write_settings(32'd0, 32'hFFFF_FFFF, 16'hFFFF, 16'd1, 8'd0, ALG_STRONG, 1'b1);
    send_item(1'b1, 1'b1);
    repeat (2) send_item(1'b0, 1'b0);
    drain();

    // Feedback FM with the envelope held
    write_settings(32'hFFFF_FFFF, 32'd0, 16'hFFFF, 16'd0, 8'hFF, ALG_MOD_FB, 1'b0);
    send_item(1'b1, 1'b0);
    repeat (4) send_item(1'b0, 1'b1);
    drain();

    // Noise mix, no modulation, slowest decay
    write_settings($urandom, $urandom, 16'd0, 16'hFFFF, 8'd128, ALG_NOISE, 1'b1);
    send_item(1'b1, 1'b1);
    repeat (3) send_item(1'b0, 1'($urandom_range(1)));
    drain();

    // Random phases: each starts with a trigger and runs ticks with rare retriggers
    for (int phase = 0; sent < RANDOM_ITEMS; phase++) begin
      steady = (phase == 3);
      write_settings(pick_step(), pick_step(), pick_depth(), pick_decay(), pick_level(),
                     2'($urandom_range(3)), $urandom_range(3) == 0);
      send_item(1'b1, 1'($urandom_range(1)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (phase == 1 && n == PHASE_ITEMS / 2) begin
          wait_results();
        end
        send_item($urandom_range(99) < 6, 1'($urandom_range(1)));
        sent++;
      end
      drain();
    end
    steady = 1'b0;

    if (errors == 0) begin
      $display("fm_drum_voice_top: match");
    end else begin
      $display("fm_drum_voice_top: mismatch");
    end
    $finish;
  end

endmodule
